/* hw/rtl/heightmap_vertex_normals_macros.svh */
// Assertion macros shared by the height-map normal block.
// No dependencies; included by files that carry concurrent checks.
`ifndef HEIGHTMAP_VERTEX_NORMALS_MACROS_SVH
`define HEIGHTMAP_VERTEX_NORMALS_MACROS_SVH

// Same-cycle implication, gated off during reset
`define HVN_ASSERT_IMPLY(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("hvn: implication check failed");

// Next-cycle implication, gated off during reset
`define HVN_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("hvn: next-cycle check failed");

`endif

/* hw/rtl/hvn_pkg.sv */
// Shared types and constants of the height-map vertex normal block.
// No dependencies; used by hvn_norm and heightmap_vertex_normals.
package hvn_pkg;

    // Register indexes of the configuration port
    localparam logic [2:0] CFG_GRID_COLUMNS = 3'd0;
    localparam logic [2:0] CFG_GRID_ROWS    = 3'd1;
    localparam logic [2:0] CFG_SPACING_X    = 3'd2;
    localparam logic [2:0] CFG_SPACING_Z    = 3'd3;
    localparam logic [2:0] CFG_HEIGHT_SCALE = 3'd4;

    // Request codes
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Vector widths: raw normals and sums, normalized components
    localparam int VEC_W  = 51;
    localparam int UNIT_W = 32;

    localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

    typedef struct packed {
        logic start;
        logic frac_short;   // 1: 14 fraction bits, 0: 30 fraction bits
    } norm_req_t;

    typedef struct packed {
        logic done;
        logic nonzero;
    } norm_rsp_t;

endpackage

/* hw/rtl/hvn_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; instanced for the height sample store.
module hvn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/hvn_norm.sv */
// Iterative vector normalizer: scale search, sum of squares, square root,
// three parallel restoring dividers and rounding. Depends on hvn_pkg.
module hvn_norm (
    input  logic                              clk,
    input  logic                              rst_n,
    input  hvn_pkg::norm_req_t                req,
    input  logic signed [hvn_pkg::VEC_W-1:0]  vx,
    input  logic signed [hvn_pkg::VEC_W-1:0]  vy,
    input  logic signed [hvn_pkg::VEC_W-1:0]  vz,
    output hvn_pkg::norm_rsp_t                rsp,
    output logic signed [hvn_pkg::UNIT_W-1:0] ux,
    output logic signed [hvn_pkg::UNIT_W-1:0] uy,
    output logic signed [hvn_pkg::UNIT_W-1:0] uz
);
    import hvn_pkg::*;

    typedef enum logic [2:0] {
        N_IDLE,
        N_SHIFT,
        N_SQ,
        N_SQRT,
        N_DIV,
        N_ROUND
    } nstate_t;

    nstate_t           state_reg;
    logic [VEC_W-1:0]  mag_reg [3];
    logic [2:0]        neg_reg;
    logic              short_reg;
    logic [5:0]        cnt_reg;
    logic [61:0]       sq_reg;
    logic [62:0]       x_reg;
    logic [62:0]       res_reg;
    logic [62:0]       bit_reg;
    logic [32:0]       rem_reg [3];
    logic [31:0]       q_reg [3];
    logic              done_reg;
    logic              nonzero_reg;
    logic signed [UNIT_W-1:0] u_reg [3];

    logic [VEC_W-1:0]  mx;
    logic [59:0]       prod;
    logic [62:0]       trial;
    logic [32:0]       len;
    logic [5:0]        last_cnt;
    logic [VEC_W-1:0]  vin [3];

    // Largest magnitude and helper values
    always_comb
    begin
        mx = mag_reg[0];
        if (mag_reg[1] > mx)
        begin
            mx = mag_reg[1];
        end
        if (mag_reg[2] > mx)
        begin
            mx = mag_reg[2];
        end
        prod     = mag_reg[cnt_reg[1:0]][29:0] * mag_reg[cnt_reg[1:0]][29:0];
        trial    = res_reg + bit_reg;
        len      = {2'b00, res_reg[30:0]};
        last_cnt = short_reg ? 6'd15 : 6'd31;
        vin[0]   = vx;
        vin[1]   = vy;
        vin[2]   = vz;
    end

    // Sequencer and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= N_IDLE;
            done_reg    <= 1'b0;
            nonzero_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                N_IDLE:
                begin
                    if (req.start)
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            neg_reg[k] <= vin[k][VEC_W-1];
                            mag_reg[k] <= vin[k][VEC_W-1] ? (~vin[k] + 1'b1) : vin[k];
                        end
                        short_reg <= req.frac_short;
                        state_reg <= N_SHIFT;
                    end
                end
                N_SHIFT:
                begin
                    // Bring the largest magnitude into [2^29, 2^30)
                    if (mx == '0)
                    begin
                        done_reg    <= 1'b1;
                        nonzero_reg <= 1'b0;
                        state_reg   <= N_IDLE;
                    end
                    else if (mx >= (VEC_W'(1) << 38))
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            mag_reg[k] <= mag_reg[k] >> 8;
                        end
                    end
                    else if (mx >= (VEC_W'(1) << 30))
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            mag_reg[k] <= mag_reg[k] >> 1;
                        end
                    end
                    else if (mx < (VEC_W'(1) << 21))
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            mag_reg[k] <= mag_reg[k] << 8;
                        end
                    end
                    else if (mx < (VEC_W'(1) << 29))
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            mag_reg[k] <= mag_reg[k] << 1;
                        end
                    end
                    else
                    begin
                        sq_reg    <= '0;
                        cnt_reg   <= '0;
                        state_reg <= N_SQ;
                    end
                end
                N_SQ:
                begin
                    // Accumulate one square per cycle
                    sq_reg  <= sq_reg + 62'(prod);
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd2)
                    begin
                        state_reg <= N_SQRT;
                    end
                end
                N_SQRT:
                begin
                    if (cnt_reg == 6'd3)
                    begin
                        x_reg   <= {1'b0, sq_reg};
                        res_reg <= '0;
                        bit_reg <= 63'(1) << 62;
                        cnt_reg <= '0;
                    end
                    else
                    begin
                        // One result bit per cycle
                        if (x_reg >= trial)
                        begin
                            x_reg   <= x_reg - trial;
                            res_reg <= (res_reg >> 1) + bit_reg;
                        end
                        else
                        begin
                            res_reg <= res_reg >> 1;
                        end
                        bit_reg <= bit_reg >> 2;
                        if (bit_reg[0])
                        begin
                            for (int k = 0; k < 3; k++)
                            begin
                                rem_reg[k] <= 33'(mag_reg[k][29:0]);
                                q_reg[k]   <= '0;
                            end
                            state_reg <= N_DIV;
                        end
                    end
                end
                N_DIV:
                begin
                    // One quotient bit per cycle on all three lanes
                    for (int k = 0; k < 3; k++)
                    begin
                        if (rem_reg[k] >= len)
                        begin
                            rem_reg[k] <= (rem_reg[k] - len) << 1;
                            q_reg[k]   <= {q_reg[k][30:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg[k] <= rem_reg[k] << 1;
                            q_reg[k]   <= {q_reg[k][30:0], 1'b0};
                        end
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == last_cnt)
                    begin
                        state_reg <= N_ROUND;
                    end
                end
                N_ROUND:
                begin
                    // Round half up and restore signs
                    for (int k = 0; k < 3; k++)
                    begin
                        if (neg_reg[k])
                        begin
                            u_reg[k] <= -$signed(32'((33'(q_reg[k]) + 33'd1) >> 1));
                        end
                        else
                        begin
                            u_reg[k] <= $signed(32'((33'(q_reg[k]) + 33'd1) >> 1));
                        end
                    end
                    done_reg    <= 1'b1;
                    nonzero_reg <= 1'b1;
                    state_reg   <= N_IDLE;
                end
                default:
                begin
                    state_reg <= N_IDLE;
                end
            endcase
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.nonzero = nonzero_reg;
    assign ux = u_reg[0];
    assign uy = u_reg[1];
    assign uz = u_reg[2];

endmodule

/* hw/rtl/heightmap_vertex_normals.sv */
// Height-map vertex normals. Load: writes one height sample, no result. Query
// outside the grid: the up vector with out_of_grid set, through S_EMIT. Query
// inside: per valid cell, reads and multiplies plus a normalization
// (32 square-root and 32 divider steps, one bit per cycle), then a final one
// on the sum; one item at a time. rst_n clears control and loads the register
// reset values; the height store is not cleared.
`include "heightmap_vertex_normals_macros.svh"

module heightmap_vertex_normals #(
    parameter int MAX_SIDE = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               req_type,
    input  logic [5:0]         row,
    input  logic [5:0]         col,
    input  logic [15:0]        height,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] normal_x,
    output logic signed [15:0] normal_y,
    output logic signed [15:0] normal_z,
    output logic               out_of_grid,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    import hvn_pkg::*;

    localparam int IW = $clog2(MAX_SIDE);
    localparam int AW = 2 * IW;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CELL,
        S_RD2,
        S_RD3,
        S_RD4,
        S_MUL1,
        S_MUL2,
        S_CGO,
        S_CWAIT,
        S_SGO,
        S_SWAIT,
        S_EMIT
    } state_t;

    state_t             state_reg;
    logic [6:0]         grid_columns_reg;
    logic [6:0]         grid_rows_reg;
    logic [15:0]        spacing_x_reg;
    logic [15:0]        spacing_z_reg;
    logic [15:0]        height_scale_reg;
    logic [5:0]         r_reg;
    logic [5:0]         c_reg;
    logic [1:0]         cell_reg;
    logic [15:0]        s1_reg;
    logic [15:0]        s2_reg;
    logic [15:0]        s3_reg;
    logic signed [33:0] p0_reg;
    logic signed [33:0] p2_reg;
    logic signed [VEC_W-1:0] raw0_reg;
    logic signed [VEC_W-1:0] raw1_reg;
    logic signed [VEC_W-1:0] raw2_reg;
    logic signed [33:0] sum_reg [3];
    logic               out_valid_reg;
    logic signed [15:0] nx_reg;
    logic signed [15:0] ny_reg;
    logic signed [15:0] nz_reg;
    logic               oog_reg;

    logic [8:0]         cols_c;
    logic [8:0]         rows_c;
    logic [8:0]         side_max;
    logic signed [9:0]  jj;
    logic signed [9:0]  ii;
    logic               cell_ok;
    logic               in_xfer;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [AW-1:0]      ram_raddr;
    logic [15:0]        ram_rdata;
    logic signed [16:0] d0;
    logic signed [16:0] d2;

    norm_req_t          nreq;
    norm_rsp_t          nrsp;
    logic signed [VEC_W-1:0] nvx;
    logic signed [VEC_W-1:0] nvy;
    logic signed [VEC_W-1:0] nvz;
    logic signed [UNIT_W-1:0] nux;
    logic signed [UNIT_W-1:0] nuy;
    logic signed [UNIT_W-1:0] nuz;

    // Clamp grid size and locate the current cell
    always_comb
    begin
        side_max = 9'(MAX_SIDE);
        if (grid_columns_reg < 7'd2)
        begin
            cols_c = 9'd2;
        end
        else if ({2'b00, grid_columns_reg} > side_max)
        begin
            cols_c = side_max;
        end
        else
        begin
            cols_c = {2'b00, grid_columns_reg};
        end
        if (grid_rows_reg < 7'd2)
        begin
            rows_c = 9'd2;
        end
        else if ({2'b00, grid_rows_reg} > side_max)
        begin
            rows_c = side_max;
        end
        else
        begin
            rows_c = {2'b00, grid_rows_reg};
        end
        jj = $signed({4'b0000, r_reg}) + $signed({9'd0, cell_reg[1]}) - 10'sd1;
        ii = $signed({4'b0000, c_reg}) + $signed({9'd0, cell_reg[0]}) - 10'sd1;
        cell_ok = (jj >= 10'sd0) && (ii >= 10'sd0)
               && (jj <= $signed({1'b0, rows_c} - 10'd2))
               && (ii <= $signed({1'b0, cols_c} - 10'd2));
        d0 = $signed({1'b0, s1_reg}) - $signed({1'b0, s2_reg});
        d2 = $signed({1'b0, s1_reg}) - $signed({1'b0, s3_reg});
    end

    // Height store write on a load transfer, read by sequencer state
    assign in_xfer   = in_valid && !in_stall;
    assign ram_we    = in_xfer && (req_type == REQ_LOAD)
                    && ({3'b000, row} < side_max) && ({3'b000, col} < side_max);
    assign ram_waddr = {IW'(row), IW'(col)};

    always_comb
    begin
        case (state_reg)
            S_RD2:   ram_raddr = {IW'(jj + 10'sd1), IW'(ii + 10'sd1)};
            S_RD3:   ram_raddr = {IW'(jj), IW'(ii)};
            default: ram_raddr = {IW'(jj + 10'sd1), IW'(ii)};
        endcase
    end

    hvn_ram #(
        .WIDTH (16),
        .DEPTH (1 << AW)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (height),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Normalizer operand select
    always_comb
    begin
        nreq.start      = (state_reg == S_CGO) || (state_reg == S_SGO);
        nreq.frac_short = (state_reg == S_SGO);
        if (state_reg == S_SGO)
        begin
            nvx = VEC_W'(sum_reg[0]);
            nvy = VEC_W'(sum_reg[1]);
            nvz = VEC_W'(sum_reg[2]);
        end
        else
        begin
            nvx = raw0_reg;
            nvy = raw1_reg;
            nvz = raw2_reg;
        end
    end

    hvn_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (nreq),
        .vx    (nvx),
        .vy    (nvy),
        .vz    (nvz),
        .rsp   (nrsp),
        .ux    (nux),
        .uy    (nuy),
        .uz    (nuz)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_columns_reg <= 7'd64;
            grid_rows_reg    <= 7'd64;
            spacing_x_reg    <= 16'd256;
            spacing_z_reg    <= 16'd256;
            height_scale_reg <= 16'd256;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_GRID_COLUMNS: grid_columns_reg <= cfg_data[6:0];
                CFG_GRID_ROWS:    grid_rows_reg    <= cfg_data[6:0];
                CFG_SPACING_X:    spacing_x_reg    <= cfg_data;
                CFG_SPACING_Z:    spacing_z_reg    <= cfg_data;
                CFG_HEIGHT_SCALE: height_scale_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Query sequencer with registered results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            cell_reg      <= '0;
        end
        else
        begin
            // Drop the result once transferred, unless a new one replaces it
            if (out_valid_reg && !out_stall && (state_reg != S_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer && (req_type == REQ_QUERY))
                    begin
                        r_reg    <= row;
                        c_reg    <= col;
                        cell_reg <= '0;
                        for (int k = 0; k < 3; k++)
                        begin
                            sum_reg[k] <= '0;
                        end
                        if (({3'b000, row} >= rows_c) || ({3'b000, col} >= cols_c))
                        begin
                            nx_reg    <= '0;
                            ny_reg    <= ONE_Q14;
                            nz_reg    <= '0;
                            oog_reg   <= 1'b1;
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            state_reg <= S_CELL;
                        end
                    end
                end
                S_CELL:
                begin
                    if (cell_ok)
                    begin
                        state_reg <= S_RD2;
                    end
                    else if (cell_reg == 2'd3)
                    begin
                        state_reg <= S_SGO;
                    end
                    else
                    begin
                        cell_reg <= cell_reg + 2'd1;
                    end
                end
                S_RD2:
                begin
                    s1_reg    <= ram_rdata;
                    state_reg <= S_RD3;
                end
                S_RD3:
                begin
                    s2_reg    <= ram_rdata;
                    state_reg <= S_RD4;
                end
                S_RD4:
                begin
                    s3_reg    <= ram_rdata;
                    state_reg <= S_MUL1;
                end
                S_MUL1:
                begin
                    // Scaled height differences
                    p0_reg    <= d0 * $signed({1'b0, height_scale_reg});
                    p2_reg    <= d2 * $signed({1'b0, height_scale_reg});
                    state_reg <= S_MUL2;
                end
                S_MUL2:
                begin
                    // Raw cell normal
                    raw0_reg  <= VEC_W'(p0_reg * $signed({1'b0, spacing_z_reg}));
                    raw1_reg  <= $signed(VEC_W'(spacing_x_reg * spacing_z_reg));
                    raw2_reg  <= VEC_W'(p2_reg * $signed({1'b0, spacing_x_reg}));
                    state_reg <= S_CGO;
                end
                S_CGO:
                begin
                    state_reg <= S_CWAIT;
                end
                S_CWAIT:
                begin
                    if (nrsp.done)
                    begin
                        if (nrsp.nonzero)
                        begin
                            sum_reg[0] <= sum_reg[0] + 34'(nux);
                            sum_reg[1] <= sum_reg[1] + 34'(nuy);
                            sum_reg[2] <= sum_reg[2] + 34'(nuz);
                        end
                        if (cell_reg == 2'd3)
                        begin
                            state_reg <= S_SGO;
                        end
                        else
                        begin
                            cell_reg  <= cell_reg + 2'd1;
                            state_reg <= S_CELL;
                        end
                    end
                end
                S_SGO:
                begin
                    state_reg <= S_SWAIT;
                end
                S_SWAIT:
                begin
                    if (nrsp.done)
                    begin
                        if (nrsp.nonzero)
                        begin
                            nx_reg <= nux[15:0];
                            ny_reg <= nuy[15:0];
                            nz_reg <= nuz[15:0];
                        end
                        else
                        begin
                            nx_reg <= '0;
                            ny_reg <= ONE_Q14;
                            nz_reg <= '0;
                        end
                        oog_reg   <= 1'b0;
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    // Hand the result to the output register when free
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        normal_x      <= nx_reg;
                        normal_y      <= ny_reg;
                        normal_z      <= nz_reg;
                        out_of_grid   <= oog_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign cfg_ready = 1'b1;

    // Checks
    `HVN_ASSERT_IMPLY(a_store_write_idle, clk, rst_n, ram_we, state_reg == S_IDLE)
    `HVN_ASSERT_IMPLY(a_norm_done_waited, clk, rst_n, nrsp.done, (state_reg == S_CWAIT || state_reg == S_SWAIT))
    `HVN_ASSERT_IMPLY(a_oog_up_vector, clk, rst_n, out_valid && out_of_grid, normal_x == 16'sd0 && normal_y == ONE_Q14 && normal_z == 16'sd0)
    `HVN_ASSERT_NEXT(a_emit_loads_out, clk, rst_n, state_reg == S_EMIT && !out_valid_reg, out_valid_reg)

endmodule
